// ===== sv/rc4_pkg.sv =====
package rc4_pkg;

    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_IDX_W     = 5;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_LEN_W     = 6;
    localparam int BYTE_W        = 8;
    localparam int TABLE_DEPTH   = 256;
    localparam int TABLE_ADDR_W  = 8;

    localparam int APB_ADDR_W    = 6;
    localparam int APB_DATA_W    = 64;
    localparam int REG_SEL_LSB   = 3;

    typedef enum logic [2:0] {
        REG_KEY_LENGTH,
        REG_KEY_WORD_0,
        REG_KEY_WORD_1,
        REG_KEY_WORD_2,
        REG_KEY_WORD_3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K_FILL,
        ST_K_RD_N,
        ST_K_RD_J,
        ST_K_WR_N,
        ST_K_WR_J,
        ST_P_RD_I,
        ST_P_RD_J,
        ST_P_WR_I,
        ST_P_WR_J,
        ST_P_OUT
    } state_t;

endpackage

// ===== sv/rc4_stream_cipher_unit.sv =====
// RC4 stream cipher, one message at a time. Each byte word on the input stream
// comes back XORed with the next keystream byte; tlast marks the end of a
// message and the next byte restarts the key schedule. The key length and the
// four 64-bit key words are written over APB at byte addresses 0, 8, 16, 24
// and 32; the user must write them only while the block is idle, which the
// block itself does not enforce; a key length of zero passes bytes through
// unchanged. The permutation lives in one 256 x 8 RAM with a single read and a
// single write port, and one byte is handled at a time: after a keyed byte is
// accepted, S[j] is read, S[i] written, S[j] written with the keystream read,
// and the output register loaded once the output is free; a pass-through byte
// goes straight to that load, and a new byte is taken from the cycle after the
// load. The first keyed byte of each message first runs the key schedule: the
// table is filled, each entry is swapped by a read, read, write, write, and
// then S[1] is read.
module rc4_stream_cipher_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rc4_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [rc4_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [rc4_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] data_byte
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,  // [7:0] out_byte
    output logic                                  m_axis_tlast
);

    import rc4_pkg::*;

    state_t                  state_reg, state_next;
    reg_idx_t                reg_sel;

    logic [KEY_LEN_W-1:0]    key_length_reg;
    logic [KEY_WORD_W-1:0]   key_word_reg [KEY_WORDS];
    logic [KEY_LEN_W-1:0]    len_eff;
    logic [BYTE_W-1:0]       key_byte;

    logic [TABLE_ADDR_W-1:0] i_reg;
    logic [TABLE_ADDR_W-1:0] j_reg;
    logic                    schedule_pending_reg;
    logic [TABLE_ADDR_W-1:0] n_reg;
    logic [KEY_IDX_W-1:0]    kidx_reg, kidx_next;
    logic [BYTE_W-1:0]       si_reg;
    logic                    fwd_reg;
    logic                    pass_reg;
    logic [BYTE_W-1:0]       data_reg;
    logic                    last_reg;
    logic                    m_valid_reg;
    logic [BYTE_W-1:0]       m_data_reg;
    logic                    m_last_reg;

    logic                    ram_we;
    logic [TABLE_ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0]       ram_wdata;
    logic                    ram_re;
    logic [TABLE_ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0]       ram_rdata;

    logic                    in_accept;
    logic                    out_load;
    logic                    cfg_write;
    logic [BYTE_W-1:0]       j_sum;
    logic [BYTE_W-1:0]       ks_addr;
    logic [BYTE_W-1:0]       keystream;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_idx_t'(paddr[APB_ADDR_W-1:REG_SEL_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            for (int w = 0; w < KEY_WORDS; w++)
            begin
                key_word_reg[w] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_KEY_LENGTH: key_length_reg  <= pwdata[KEY_LEN_W-1:0];
                REG_KEY_WORD_0: key_word_reg[0] <= pwdata;
                REG_KEY_WORD_1: key_word_reg[1] <= pwdata;
                REG_KEY_WORD_2: key_word_reg[2] <= pwdata;
                REG_KEY_WORD_3: key_word_reg[3] <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_KEY_LENGTH: prdata = APB_DATA_W'(key_length_reg);
            REG_KEY_WORD_0: prdata = key_word_reg[0];
            REG_KEY_WORD_1: prdata = key_word_reg[1];
            REG_KEY_WORD_2: prdata = key_word_reg[2];
            REG_KEY_WORD_3: prdata = key_word_reg[3];
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- key
    assign len_eff  = (key_length_reg > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                      KEY_LEN_W'(MAX_KEY_BYTES) : key_length_reg;
    assign key_byte = key_word_reg[kidx_reg[KEY_IDX_W-1:3]][kidx_reg[2:0]*BYTE_W +: BYTE_W];
    assign kidx_next = (({1'b0, kidx_reg} + KEY_LEN_W'(1)) == len_eff) ?
                       '0 : kidx_reg + KEY_IDX_W'(1);

    // ---------------------------------------------------------------- table
    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign j_sum     = j_reg + ram_rdata + key_byte;
    assign ks_addr   = si_reg + ram_rdata;
    // keystream address landing on j reads the value written in the same cycle
    assign keystream = fwd_reg ? si_reg : ram_rdata;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == ST_P_OUT) && (!m_valid_reg || m_axis_tready);

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (len_eff == '0)
                    begin
                        state_next = ST_P_OUT;
                    end
                    else if (schedule_pending_reg)
                    begin
                        state_next = ST_K_FILL;
                    end
                    else
                    begin
                        state_next = ST_P_RD_J;
                    end
                end
            end
            ST_K_FILL: if (n_reg == '1) state_next = ST_K_RD_N;
            ST_K_RD_N: state_next = ST_K_RD_J;
            ST_K_RD_J: state_next = ST_K_WR_N;
            ST_K_WR_N: state_next = ST_K_WR_J;
            ST_K_WR_J: state_next = (n_reg == '1) ? ST_P_RD_I : ST_K_RD_N;
            ST_P_RD_I: state_next = ST_P_RD_J;
            ST_P_RD_J: state_next = ST_P_WR_I;
            ST_P_WR_I: state_next = ST_P_WR_J;
            ST_P_WR_J: state_next = ST_P_OUT;
            ST_P_OUT:  if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_re        = 1'b1;
                ram_raddr     = i_reg + TABLE_ADDR_W'(1);
            end
            ST_K_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = n_reg;
            end
            ST_K_RD_N:
            begin
                ram_re    = 1'b1;
                ram_raddr = n_reg;
            end
            ST_K_RD_J:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_sum;
            end
            ST_K_WR_N:
            begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = ram_rdata;
            end
            ST_K_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
            end
            ST_P_RD_I:
            begin
                ram_re    = 1'b1;
                ram_raddr = i_reg + TABLE_ADDR_W'(1);
            end
            ST_P_RD_J:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_reg + ram_rdata;
            end
            ST_P_WR_I:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = ram_rdata;
            end
            ST_P_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                ram_re    = 1'b1;
                ram_raddr = ks_addr;
            end
            ST_P_OUT:  ;
            default:   ;
        endcase
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            i_reg                <= '0;
            j_reg                <= '0;
            schedule_pending_reg <= 1'b1;
            m_valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_accept && (len_eff != '0) && schedule_pending_reg)
            begin
                schedule_pending_reg <= 1'b0;
            end
            else if (out_load && last_reg)
            begin
                schedule_pending_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_K_FILL: j_reg <= '0;
                ST_K_RD_J: j_reg <= j_sum;
                ST_K_WR_J:
                begin
                    if (n_reg == '1)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end
                end
                ST_P_RD_J:
                begin
                    i_reg <= i_reg + TABLE_ADDR_W'(1);
                    j_reg <= j_reg + ram_rdata;
                end
                default: ;
            endcase

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
            pass_reg <= (len_eff == '0);
            n_reg    <= '0;
        end

        unique case (state_reg)
            ST_K_FILL:
            begin
                n_reg    <= n_reg + TABLE_ADDR_W'(1);
                kidx_reg <= '0;
            end
            ST_K_RD_J: si_reg <= ram_rdata;
            ST_K_WR_J:
            begin
                n_reg    <= n_reg + TABLE_ADDR_W'(1);
                kidx_reg <= kidx_next;
            end
            ST_P_RD_J: si_reg  <= ram_rdata;
            ST_P_WR_J: fwd_reg <= (ks_addr == j_reg);
            default: ;
        endcase

        if (out_load)
        begin
            m_data_reg <= pass_reg ? data_reg : (data_reg ^ keystream);
            m_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== sv/rc4_ram.sv =====
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/rc4_checker.sv =====
module rc4_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
    input logic                           m_axis_tlast
);

    logic in_acc;
    logic m_valid_q_reg;
    logic owed_reg;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // set while an accepted word has not yet shown up on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_q_reg <= 1'b0;
            owed_reg      <= 1'b0;
        end
        else
        begin
            m_valid_q_reg <= m_axis_tvalid;
            if (in_acc)
            begin
                owed_reg <= 1'b1;
            end
            else if (m_axis_tvalid && !m_valid_q_reg)
            begin
                owed_reg <= 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("second word taken while one is in flight");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> owed_reg)
        else $error("result without an accepted word");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rc4_pkg::*;

    localparam int ITEMS_TOTAL  = 1950;
    localparam int IDLE_CYCLES  = 8;
    localparam int MAX_GAP      = 8;
    localparam int LIMIT_CYCLES = 4 * (ITEMS_TOTAL + 100) * (1280 + 5 + MAX_GAP + 16);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_word_t;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata;  // [7:0] data_byte
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [7:0]              m_axis_tdata;  // [7:0] out_byte
    logic                    m_axis_tlast;

    rc4_stream_cipher_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow of the block's configuration and cipher state
    logic [KEY_LEN_W-1:0]  cfg_key_len;
    logic [KEY_WORD_W-1:0] cfg_key_word [KEY_WORDS];
    logic [7:0]            perm_model [TABLE_DEPTH];
    logic [7:0]            ks_i;
    logic [7:0]            ks_j;
    logic                  rekey_pending;

    cipher_word_t expected_words [$];

    int errors;
    int cycle_count;
    int items_sent;
    int words_checked;
    int messages_sent;
    int config_writes;
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic key_schedule(input int len);
        logic [7:0] j;
        logic [7:0] t;
        logic [7:0] kb;
        int         k;
        for (int n = 0; n < TABLE_DEPTH; n++)
            perm_model[n] = n[7:0];
        j = 8'd0;
        for (int n = 0; n < TABLE_DEPTH; n++)
        begin
            k  = n % len;
            kb = cfg_key_word[k >> 3][(k & 7) * 8 +: 8];
            j  = j + perm_model[n] + kb;
            t  = perm_model[n];
            perm_model[n] = perm_model[j];
            perm_model[j] = t;
        end
        ks_i = 8'd0;
        ks_j = 8'd0;
    endtask

    task automatic predict_cipher(input logic [7:0] din, input logic lin,
                                  output cipher_word_t res);
        int         len;
        logic [7:0] t;
        logic [7:0] idx;
        len = (cfg_key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(cfg_key_len);
        res.data = din;
        res.last = lin;
        if (len != 0)
        begin
            if (rekey_pending)
            begin
                key_schedule(len);
                rekey_pending = 1'b0;
            end
            ks_i = ks_i + 8'd1;
            ks_j = ks_j + perm_model[ks_i];
            t = perm_model[ks_i];
            perm_model[ks_i] = perm_model[ks_j];
            perm_model[ks_j] = t;
            idx = perm_model[ks_i] + perm_model[ks_j];
            res.data = din ^ perm_model[idx];
        end
        if (lin)
            rekey_pending = 1'b1;
    endtask

    // all stimulus tasks are entered and left at a falling edge
    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(int'(idx) << REG_SEL_LSB);
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_KEY_LENGTH)
            cfg_key_len = val[KEY_LEN_W-1:0];
        else
            cfg_key_word[int'(idx) - 1] = val;
        config_writes++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_word(input logic [7:0] din, input logic lin);
        cipher_word_t res;
        int           gap;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = din;
        s_axis_tlast  = lin;
        do @(posedge clk); while (!s_axis_tready);
        predict_cipher(din, lin, res);
        expected_words.push_back(res);
        items_sent++;
        if (lin)
            messages_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, MAX_GAP);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_message(input int len);
        for (int n = 0; n < len; n++)
            send_word(8'($urandom), n == len - 1);
    endtask

    function automatic logic [63:0] random_key_word();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] random_key_length();
        case ($urandom_range(0, 11))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return 64'd32;
            3:       return 64'($urandom_range(33, 63));
            default: return 64'($urandom_range(1, 32));
        endcase
    endfunction

    always @(posedge clk)
    begin
        cipher_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, actual data %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                words_checked++;
                if (m_axis_tdata !== exp_w.data)
                begin
                    $display("%0t: data mismatch, expected %h actual %h",
                             $time, exp_w.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== exp_w.last)
                begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, exp_w.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure, independent of the sender
    initial
    begin
        int mode;
        int span;
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(30, 300);
            repeat (span)
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = (phase % 5) != 0;
                endcase
            end
        end
    end

    task automatic test_passthrough_after_reset();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b1);
    endtask

    task automatic test_key_extremes();
        wait_idle();
        apb_write(REG_KEY_WORD_0, 64'h0);
        apb_write(REG_KEY_LENGTH, 64'd1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_idle();
        apb_write(REG_KEY_WORD_0, '1);
        apb_write(REG_KEY_WORD_1, '1);
        apb_write(REG_KEY_WORD_2, '1);
        apb_write(REG_KEY_WORD_3, '1);
        apb_write(REG_KEY_LENGTH, 64'd32);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h5A, 1'b1);
        wait_idle();
        for (int w = 0; w < KEY_WORDS; w++)
            apb_write(reg_idx_t'(w + 1), {$urandom, $urandom});
        // length beyond the key store saturates
        apb_write(REG_KEY_LENGTH, 64'd63);
        send_message(3);
    endtask

    task automatic test_key_change_mid_message();
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd5);
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        wait_idle();
        apb_write(REG_KEY_WORD_0, {$urandom, $urandom});
        apb_write(REG_KEY_LENGTH, 64'd7);
        send_word(8'h56, 1'b0);
        send_word(8'h78, 1'b1);
        send_message(2);
    endtask

    task automatic test_zero_length_mid_message();
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd8);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd0);
        send_word(8'hC3, 1'b0);
        send_word(8'h3C, 1'b0);
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd8);
        send_word(8'h7E, 1'b0);
        send_word(8'hE7, 1'b1);
    endtask

    task automatic test_random_messages();
        int len;
        while (items_sent < ITEMS_TOTAL)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_idle();
                for (int w = 0; w < KEY_WORDS; w++)
                    if ($urandom_range(0, 1))
                        apb_write(reg_idx_t'(w + 1), random_key_word());
                apb_write(REG_KEY_LENGTH, random_key_length());
            end
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(65, 160);
                1, 2, 3: len = $urandom_range(25, 64);
                default: len = $urandom_range(1, 24);
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                // message broken by a reconfiguration part way through
                for (int n = 0; n < len / 2; n++)
                    send_word(8'($urandom), 1'b0);
                wait_idle();
                if ($urandom_range(0, 1))
                    apb_write(REG_KEY_WORD_0, random_key_word());
                apb_write(REG_KEY_LENGTH, random_key_length());
                send_message(len - len / 2 + 1);
            end
            else
                send_message(len);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        cfg_key_len   = '0;
        for (int w = 0; w < KEY_WORDS; w++)
            cfg_key_word[w] = '0;
        for (int n = 0; n < TABLE_DEPTH; n++)
            perm_model[n] = 8'h00;
        ks_i          = 8'd0;
        ks_j          = 8'd0;
        rekey_pending = 1'b1;
        errors        = 0;
        cycle_count   = 0;
        items_sent    = 0;
        words_checked = 0;
        messages_sent = 0;
        config_writes = 0;
        burst_left    = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_passthrough_after_reset();
        test_key_extremes();
        test_key_change_mid_message();
        test_zero_length_mid_message();
        test_random_messages();

        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d cipher words in %0d messages with %0d register writes,",
                 words_checked, messages_sent, config_writes);
        $display("covering pass-through, key lengths 1 to 32 and saturation, rekeying.");
        if (errors == 0 && expected_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
